[src/assert_macros.svh]
// Assertion macros shared by the verification checkers of the voxel fusion block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define TVFU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TVFU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tvfu_pkg.sv]
// Package for the voxel fusion block: field widths, status codes, shared types.
// No dependencies; imported by every file of the block but tvfu_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

package tvfu_pkg;

  localparam int COORD_W     = 5;
  localparam int DIST_W      = 16;
  localparam int OBS_W       = 16;
  localparam int WEIGHT_W    = 24;
  localparam int TRUNC_W     = 15;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = DIST_W + WEIGHT_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = ENTRY_W;

  // Exact weight sum, product and quotient widths of the averaging datapath.
  localparam int SUM_W      = WEIGHT_W + 1;
  localparam int PROD_W     = DIST_W + SUM_W;
  localparam int MAG_W      = PROD_W - 1;
  localparam int DIVIDEND_W = PROD_W;
  localparam int QUOT_W     = DIST_W;

  localparam int GRID_DIM_DEF = 32;

  localparam logic [TRUNC_W-1:0]  TRUNC_RESET = 15'd4096;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX  = '1;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED     = 2'd0,
    ST_SKIPPED     = 2'd1,
    ST_ZERO_WEIGHT = 2'd2
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

[src/tvfu_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the voxel distance and weight store.
`timescale 1ns / 1ps
`default_nettype none

module tvfu_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/tvfu_div.sv]
// Iterative restoring divider, one quotient bit per cycle, for the weighted average.
// Depends on tvfu_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module tvfu_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [tvfu_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [tvfu_pkg::SUM_W-1:0]      divisor,
  output logic      [tvfu_pkg::QUOT_W-1:0]     quotient,
  output tvfu_pkg::div_status_t                status
);

  import tvfu_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [SUM_W-1:0]  rem;
  logic [QUOT_W-1:0] quo;
  logic [SUM_W-1:0]  dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [SUM_W:0]    trial;
  logic [SUM_W+1:0]  diff;
  logic              ge;
  logic [SUM_W-1:0]  rem_next;

  // The caller guarantees the upper dividend part is below the divisor, so the
  // quotient fits in QUOT_W bits and only QUOT_W steps are needed.
  always_comb begin
    trial    = {rem, quo[QUOT_W-1]};
    diff     = {1'b0, trial} - {2'b00, dvs};
    ge       = !diff[SUM_W+1];
    rem_next = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DIVIDEND_W-1:QUOT_W];
      quo <= dividend[QUOT_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[QUOT_W-2:0], ge};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

[src/tsdf_voxel_fusion_update.sv]
// Top level of the voxel fusion block: sequencer, shared multiplier and voxel store.
// Depends on tvfu_pkg, tvfu_ram and tvfu_div.
//
// Usage: each input beat on the s_ channel names one voxel of a GRID_DIM^3 grid
// and carries an observed signed distance (Q4.12) and an observation weight (Q8.8).
// Each input beat produces exactly one output beat on the m_ channel reporting
// the voxel's distance and accumulated weight after the step, plus a status code.
// The truncation distance is written through the cfg_ channel, which is always
// ready; write it only while the block has no item in flight.
// Sequencing: an updated voxel passes the read, load, two multiply, add, magnitude,
// divider start, divider wait and write states before m_tvalid; a new input beat is
// taken only after the previous result has moved to the output register. The 16-step
// divider forms the rounded weighted average; the multiplies run one after the other
// through a single multiplier. Skipped and zero-weight items bypass both units.
// Reset: after rst falls, a clearing pass writes zero to every voxel entry, one
// entry per cycle, GRID_DIM^3 cycles (32768 at the default size); s_tready stays
// low until it ends. The truncation distance resets to 1.0 (4096).
// Stalls: the result waits in the output register while m_tready is low; the
// block may accept and process the next item meanwhile, and holds its next
// result until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module tsdf_voxel_fusion_update #(
  parameter int GRID_DIM = tvfu_pkg::GRID_DIM_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input stream. s_tdata, from bit 0 up: voxel_x[4:0], voxel_y[9:5],
  // voxel_z[14:10], signed_dist[30:15], obs_weight[46:31], zero pad [47].
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [tvfu_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Result stream. m_tdata, from bit 0 up: fused_dist[15:0], fused_weight[39:16].
  // m_tuser: status[1:0].
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [tvfu_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic      [tvfu_pkg::STATUS_W-1:0]     m_tuser,
  // Truncation distance register write.
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tvfu_pkg::TRUNC_W-1:0]      cfg_data
);

  import tvfu_pkg::*;

  localparam int VOXELS     = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int AW         = $clog2(VOXELS);
  localparam int CW         = $clog2(GRID_DIM);
  localparam int WRAP_W     = (CW + 1 > COORD_W) ? CW + 1 : COORD_W;
  localparam int WRAP_STEPS = (32 + GRID_DIM - 1) / GRID_DIM;

  localparam logic [AW-1:0] ROW_STRIDE   = AW'(GRID_DIM);
  localparam logic [AW-1:0] PLANE_STRIDE = AW'(GRID_DIM * GRID_DIM);
  localparam logic [AW-1:0] LAST_ADDR    = AW'(VOXELS - 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LOAD,
    S_MUL_DW,
    S_MUL_TW,
    S_ADD,
    S_ABS,
    S_DIV_START,
    S_DIV_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

  // A coordinate of GRID_DIM or more wraps around the grid.
  function automatic logic [CW-1:0] wrap_coord(input logic [COORD_W-1:0] v);
    logic [WRAP_W-1:0] r;
    r = WRAP_W'(v);
    for (int i = 0; i < WRAP_STEPS; i++) begin
      if (r >= WRAP_W'(GRID_DIM)) begin
        r = r - WRAP_W'(GRID_DIM);
      end
    end
    return CW'(r);
  endfunction

  state_t                    state;
  logic [AW-1:0]             clr_addr;
  logic [TRUNC_W-1:0]        trunc;

  logic [AW-1:0]             addr;
  logic signed [DIST_W-1:0]  sd_reg;
  logic [OBS_W-1:0]          ow_reg;
  logic signed [DIST_W-1:0]  d_old;
  logic [WEIGHT_W-1:0]       w_old;
  logic signed [DIST_W-1:0]  t_reg;
  logic [SUM_W-1:0]          sum;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic                      neg;
  logic [MAG_W-1:0]          mag;
  logic [DIST_W-1:0]         res_dist;
  logic [WEIGHT_W-1:0]       res_weight;
  status_t                   res_status;

  // Input unpacking and voxel address.
  logic [COORD_W-1:0]        in_x;
  logic [COORD_W-1:0]        in_y;
  logic [COORD_W-1:0]        in_z;
  logic [AW-1:0]             addr_in;

  // Store port.
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata;
  logic [ENTRY_W-1:0]        ram_rdata;
  logic signed [DIST_W-1:0]  rd_dist;
  logic [WEIGHT_W-1:0]       rd_weight;

  // Truncation test, clamp and weight sum, evaluated while the entry is loaded.
  logic signed [DIST_W:0]    sd_ext;
  logic signed [DIST_W:0]    tr_ext;
  logic                      skip;
  logic signed [DIST_W-1:0]  t_clamp;
  logic [SUM_W-1:0]          sum_c;

  // Shared multiplier.
  logic signed [DIST_W:0]    mul_a;
  logic signed [SUM_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic signed [PROD_W-1:0]  acc_neg;
  logic                      div_start;
  logic [DIVIDEND_W-1:0]     div_dividend;
  logic [QUOT_W-1:0]         div_quot;
  logic [QUOT_W-1:0]         quot_neg;
  div_status_t               div_st;

  // The finished result moves into the output register once that register is free.
  logic                      out_load;

  assign in_x = s_tdata[COORD_W-1:0];
  assign in_y = s_tdata[2*COORD_W-1:COORD_W];
  assign in_z = s_tdata[3*COORD_W-1:2*COORD_W];

  assign addr_in = AW'(wrap_coord(in_x))
                 + ROW_STRIDE * AW'(wrap_coord(in_y))
                 + PLANE_STRIDE * AW'(wrap_coord(in_z));

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign rd_dist   = ram_rdata[DIST_W-1:0];
  assign rd_weight = ram_rdata[ENTRY_W-1:DIST_W];

  // The clamp only bounds the distance from above; s <= -T means skip.
  always_comb begin
    sd_ext  = {sd_reg[DIST_W-1], sd_reg};
    tr_ext  = {2'b00, trunc};
    skip    = (sd_ext <= -tr_ext);
    t_clamp = (sd_ext < tr_ext) ? sd_reg : tr_ext[DIST_W-1:0];
    sum_c   = SUM_W'(rd_weight) + SUM_W'(ow_reg);
  end

  // One signed multiplier serves both products: D*W, then t*w.
  always_comb begin
    if (state == S_MUL_TW) begin
      mul_a = {t_reg[DIST_W-1], t_reg};
      mul_b = {{(SUM_W - OBS_W){1'b0}}, ow_reg};
    end else begin
      mul_a = {d_old[DIST_W-1], d_old};
      mul_b = {1'b0, w_old};
    end
  end
  assign mul_p = mul_a * mul_b;

  assign acc_neg = -acc;

  // Adding half the divisor before the truncating divide rounds the magnitude
  // to nearest with ties away from zero.
  assign div_start    = (state == S_DIV_START);
  assign div_dividend = DIVIDEND_W'(mag) + DIVIDEND_W'(sum[SUM_W-1:1]);
  assign quot_neg     = ~div_quot + 1'b1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = {res_weight, res_dist};
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_WRITE) begin
      ram_we = 1'b1;
    end
  end

  tvfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (VOXELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  tvfu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum),
    .quotient (div_quot),
    .status   (div_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc <= TRUNC_RESET;
    end else if (cfg_valid) begin
      trunc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {res_weight, res_dist};
        m_tuser  <= res_status;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            addr   <= addr_in;
            sd_reg <= s_tdata[3*COORD_W+DIST_W-1:3*COORD_W];
            ow_reg <= s_tdata[3*COORD_W+DIST_W+OBS_W-1:3*COORD_W+DIST_W];
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          d_old      <= rd_dist;
          w_old      <= rd_weight;
          t_reg      <= t_clamp;
          sum        <= sum_c;
          res_dist   <= rd_dist;
          res_weight <= rd_weight;
          if (skip) begin
            res_status <= ST_SKIPPED;
            state      <= S_DONE;
          end else if (sum_c == '0) begin
            res_status <= ST_ZERO_WEIGHT;
            state      <= S_DONE;
          end else begin
            res_status <= ST_UPDATED;
            state      <= S_MUL_DW;
          end
        end
        S_MUL_DW: begin
          prod  <= mul_p;
          state <= S_MUL_TW;
        end
        S_MUL_TW: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_ADD;
        end
        S_ADD: begin
          acc   <= acc + prod;
          state <= S_ABS;
        end
        S_ABS: begin
          neg   <= acc[PROD_W-1];
          mag   <= acc[PROD_W-1] ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];
          state <= S_DIV_START;
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_st.done) begin
            res_dist   <= neg ? quot_neg : div_quot;
            res_weight <= sum[SUM_W-1] ? WEIGHT_MAX : sum[WEIGHT_W-1:0];
            state      <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/tvfu_checker.sv]
// Port-level checker for the voxel fusion block, attached to the top level by bind.
// Depends on tvfu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tvfu_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [tvfu_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire logic [tvfu_pkg::STATUS_W-1:0]     m_tuser
);

  import tvfu_pkg::*;

  logic in_beat;

  assign in_beat  = s_tvalid && s_tready;

  // A result that is offered stays offered until taken.
  `TVFU_ASSERT(a_out_valid_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

  // A stalled result keeps its payload.
  `TVFU_ASSERT(a_out_data_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  // One item at a time: an accepted beat closes the input for the next cycle.
  `TVFU_ASSERT(a_one_in_flight, clk, rst, in_beat |=> !s_tready, "input accepted on consecutive cycles")

  // An update always leaves a nonzero accumulated weight.
  `TVFU_ASSERT(a_update_weight, clk, rst, m_tvalid && m_tuser == ST_UPDATED |-> m_tdata[OUT_TDATA_W-1:DIST_W] != '0, "updated voxel reports zero weight")

  // The clearing pass after reset keeps the input closed.
  `TVFU_ASSERT_ALWAYS(a_clear_after_reset, clk, rst |=> !s_tready && !m_tvalid, "input open right after reset")

endmodule

bind tsdf_voxel_fusion_update tvfu_checker u_tvfu_checker (.*);

`default_nettype wire

[verif/tsdf_voxel_fusion_update_tb.sv]
// Self-checking bench for tsdf_voxel_fusion_update: random and directed observations,
// bursty input pacing, patterned output stalls and a long back-pressure stretch.
// Depends on tvfu_pkg and the RTL top level; a scoreboard class predicts each result beat.
`timescale 1ns / 1ps

module tsdf_voxel_fusion_update_tb;
  import tvfu_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int VOXELS      = GRID_DIM_DEF * GRID_DIM_DEF * GRID_DIM_DEF;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 800;
  localparam logic [TRUNC_W-1:0] TRUNC_MAX  = '1;
  localparam logic [TRUNC_W-1:0] TRUNC_MIN  = 15'd1;
  localparam logic [TRUNC_W-1:0] TRUNC_ZERO = '0;

  // One observation as it sits in s_tdata, x in the lowest bits.
  typedef struct packed {
    logic [OBS_W-1:0]   weight;
    logic [DIST_W-1:0]  distance;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } voxel_obs_t;

  // One voxel report as it sits in {m_tuser, m_tdata}.
  typedef struct packed {
    status_t             status;
    logic [WEIGHT_W-1:0] weight;
    logic [DIST_W-1:0]   distance;
  } voxel_entry_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} sink_mode_t;

  class fusion_scoreboard;
    logic [DIST_W-1:0]   dist_mem [VOXELS];
    logic [WEIGHT_W-1:0] weight_mem [VOXELS];
    logic [TRUNC_W-1:0]  trunc;
    voxel_entry_t        expected_q [$];
    int unsigned errors, n_inputs, n_updated, n_skipped, n_zero, n_ceiling;

    function new();
      trunc = TRUNC_RESET;
      foreach (dist_mem[i]) begin
        dist_mem[i]   = '0;
        weight_mem[i] = '0;
      end
    endfunction

    function void set_trunc(logic [TRUNC_W-1:0] value);
      trunc = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Fuse one accepted observation into the shadow grid and queue the report.
    function void note_input(voxel_obs_t o);
      int unsigned idx;
      longint d_old, w_old, s, w, tr, t, sum, num, mag, q;
      voxel_entry_t e;
      idx   = {o.z, o.y, o.x};
      d_old = $signed(dist_mem[idx]);
      w_old = weight_mem[idx];
      s     = $signed(o.distance);
      w     = o.weight;
      tr    = trunc;
      e.status = ST_UPDATED;
      if (s <= -tr) begin
        e.status = ST_SKIPPED;
      end else begin
        t   = (s < tr) ? s : tr;
        sum = w_old + w;
        if (sum == 0) begin
          e.status = ST_ZERO_WEIGHT;
        end else begin
          num = d_old * w_old + t * w;
          mag = (num < 0) ? -num : num;
          // Round half away from zero; the average lies between D and t, so it fits.
          q = (mag + sum / 2) / sum;
          dist_mem[idx]   = (num < 0) ? DIST_W'(-q) : DIST_W'(q);
          weight_mem[idx] = (sum > WEIGHT_MAX) ? WEIGHT_MAX : WEIGHT_W'(sum);
        end
      end
      e.distance = dist_mem[idx];
      e.weight   = weight_mem[idx];
      expected_q.push_back(e);
      n_inputs++;
      case (e.status)
        ST_UPDATED: begin
          n_updated++;
          if (e.weight == WEIGHT_MAX) n_ceiling++;
        end
        ST_SKIPPED:     n_skipped++;
        ST_ZERO_WEIGHT: n_zero++;
        default: ;
      endcase
    endfunction

    function void check_result(voxel_entry_t got);
      voxel_entry_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d dist %0d weight %0d",
               got.status, $signed(got.distance), got.weight);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $error("fused_dist: expected %0d, got %0d", $signed(want.distance),
               $signed(got.distance));
        errors++;
      end
      if (got.weight !== want.weight) begin
        $error("fused_weight: expected %0d, got %0d", want.weight, got.weight);
        errors++;
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic [STATUS_W-1:0]     m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [TRUNC_W-1:0]      cfg_data  = '0;

  fusion_scoreboard fuse_sb = new();
  int unsigned burst_left = 0;
  int unsigned n_settings = 1;

  tsdf_voxel_fusion_update #(
    .GRID_DIM(GRID_DIM_DEF)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sample every channel at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) fuse_sb.set_trunc(cfg_data);
      if (s_tvalid && s_tready) fuse_sb.note_input(voxel_obs_t'(s_tdata[$bits(voxel_obs_t)-1:0]));
      if (m_tvalid && m_tready) fuse_sb.check_result(voxel_entry_t'({m_tuser, m_tdata}));
    end
  end

  // Result sink: switches between stall patterns, and once holds off for a long time
  // so that the output register fills and the block has to refuse input beats.
  initial begin : result_sink
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned rx_cycle;
    bit          held;
    mode      = RX_OPEN;
    mode_left = 0;
    rx_cycle  = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (!held && fuse_sb.n_inputs >= HOLD_AFTER) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 400);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= rx_cycle[2];
      endcase
    end
  end

  function automatic voxel_obs_t obs(int x, int y, int z, int d, int w);
    voxel_obs_t o;
    o.x        = COORD_W'(x);
    o.y        = COORD_W'(y);
    o.z        = COORD_W'(z);
    o.distance = DIST_W'(d);
    o.weight   = OBS_W'(w);
    return o;
  endfunction

  function automatic voxel_obs_t random_obs(int tr);
    voxel_obs_t  o;
    int unsigned k;
    int          d;
    k = $urandom_range(0, 7);
    if ($urandom_range(0, 9) < 7) begin
      // A handful of busy voxels, so entries build up a long history.
      o.x = COORD_W'(3 * k);
      o.y = COORD_W'(31 - k);
      o.z = COORD_W'(4 * k + 3);
    end else begin
      o.x = COORD_W'($urandom);
      o.y = COORD_W'($urandom);
      o.z = COORD_W'($urandom);
    end
    case ($urandom_range(0, 3))
      0:       d = int'($urandom);
      1:       d = ($urandom_range(0, 1) ? tr : -tr) + int'($urandom_range(0, 4)) - 2;
      default: d = int'($urandom_range(0, 2 * tr)) - tr;
    endcase
    o.distance = DIST_W'(d);
    case ($urandom_range(0, 9))
      0:       o.weight = '0;
      1:       o.weight = '1;
      2, 3:    o.weight = OBS_W'($urandom_range(1, 255));
      default: o.weight = OBS_W'($urandom);
    endcase
    return o;
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic offer_observation(voxel_obs_t o);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, o};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic sender_pause();
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_fusion_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (fuse_sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_trunc(logic [TRUNC_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic fuse_random(int tr, int unsigned count);
    repeat (count) begin
      offer_observation(random_obs(tr));
      sender_pause();
    end
    wait_fusion_idle();
  endtask

  // Pound one voxel with near-maximum weights until its weight pins at the ceiling.
  task automatic saturate_voxel(int tr, int unsigned count);
    voxel_obs_t o;
    repeat (count) begin
      o          = random_obs(tr);
      o.x        = 5'd9;
      o.y        = 5'd20;
      o.z        = 5'd3;
      o.distance = DIST_W'(int'($urandom_range(0, 2 * tr - 1)) - tr + 1);
      if ($urandom_range(0, 15) != 0) o.weight = OBS_W'($urandom_range(65000, 65535));
      offer_observation(o);
      sender_pause();
    end
    wait_fusion_idle();
  endtask

  initial begin : stimulus
    int tr;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the reset truncation distance of 4096.
    offer_observation(obs(0, 0, 0, 0, 0));              // zero total weight on empty voxel
    offer_observation(obs(0, 0, 0, -4096, 256));        // exactly minus T: skipped
    offer_observation(obs(0, 0, 0, -4095, 256));        // just inside the band
    offer_observation(obs(0, 0, 0, 32767, 65535));      // clamped to T
    offer_observation(obs(0, 0, 0, 4095, 0));           // zero weight on a filled voxel
    offer_observation(obs(31, 31, 31, -32768, 65535));  // most negative distance
    offer_observation(obs(31, 31, 31, 32767, 0));
    offer_observation(obs(31, 31, 31, 4096, 65535));    // exactly T
    offer_observation(obs(31, 31, 31, 4097, 1));
    offer_observation(obs(31, 0, 17, -1, 1));
    offer_observation(obs(0, 31, 0, 1, 65535));
    offer_observation(obs(0, 0, 31, -32767, 128));
    offer_observation(obs(21, 10, 5, 'h5555, 'hAAAA));
    offer_observation(obs(10, 21, 26, -21846, 'h5555));
    offer_observation(obs(21, 10, 5, -100, 'hAAAA));
    offer_observation(obs(21, 10, 5, 3, 3));
    wait_fusion_idle();

    fuse_random(int'(TRUNC_RESET), 300);
    write_trunc(TRUNC_MAX);
    fuse_random(int'(TRUNC_MAX), 250);
    write_trunc(TRUNC_MIN);
    fuse_random(int'(TRUNC_MIN), 150);
    // A zero distance register turns the test into s > 0 with a zero clamp.
    write_trunc(TRUNC_ZERO);
    fuse_random(int'(TRUNC_ZERO), 60);

    tr = $urandom_range(1, int'(TRUNC_MAX));
    write_trunc(TRUNC_W'(tr));
    saturate_voxel(tr, 320);

    tr = $urandom_range(2, 256);
    write_trunc(TRUNC_W'(tr));
    fuse_random(tr, 150);
    tr = $urandom_range(8192, int'(TRUNC_MAX) - 1);
    write_trunc(TRUNC_W'(tr));
    fuse_random(tr, 150);
    tr = $urandom_range(1, int'(TRUNC_MAX));
    write_trunc(TRUNC_W'(tr));
    fuse_random(tr, 150);

    repeat (40) @(posedge clk);
    $display("Fused %0d observations over %0d truncation settings: %0d updated, %0d skipped,",
             fuse_sb.n_inputs, n_settings, fuse_sb.n_updated, fuse_sb.n_skipped);
    $display("%0d with zero total weight, %0d updates at the weight ceiling; %0d mismatches.",
             fuse_sb.n_zero, fuse_sb.n_ceiling, fuse_sb.errors);
    if (fuse_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog that fails the run if the stimulus has not finished; it allows for the clearing pass.
  initial begin : watchdog
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tvfu_pkg.sv
src/tvfu_ram.sv
src/tvfu_div.sv
src/tsdf_voxel_fusion_update.sv
src/tvfu_checker.sv
verif/tsdf_voxel_fusion_update_tb.sv
